[rtl/gas_sensor_ppm_converter_macros.svh]
// Assertion helpers for the gas sensor converter
`ifndef GAS_SENSOR_PPM_CONVERTER_MACROS_SVH
`define GAS_SENSOR_PPM_CONVERTER_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define GSPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Trigger implies the consequence in the next cycle
`define GSPC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gspc_pkg.sv]
package gspc_pkg;

  localparam int MAX24 = 24'hFFFFFF;
  localparam int CAL_SAMPLES_DEF = 25;
  localparam int ADC_BITS_DEF = 12;
  // ro = sum * 100 / (CAL_SAMPLES * 983)
  localparam int RO_MUL = 100;
  localparam int RO_DIV = 983;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES,
    ST_DIV,
    ST_DIVEND,
    ST_POST,
    ST_MULCAL,
    ST_NORM,
    ST_SQ,
    ST_LOGEND,
    ST_MULP,
    ST_EXP,
    ST_MULA,
    ST_SHIFT,
    ST_OUT
  } gspc_state_e;

  // 2^(2^-(k+1)) in Q30
  function automatic logic [30:0] exp2_root(input logic [3:0] k);
    logic [30:0] r;
    case (k)
      4'd0:    r = 31'd1518500250;
      4'd1:    r = 31'd1276901417;
      4'd2:    r = 31'd1170923762;
      4'd3:    r = 31'd1121280436;
      4'd4:    r = 31'd1097253708;
      4'd5:    r = 31'd1085434106;
      4'd6:    r = 31'd1079572136;
      4'd7:    r = 31'd1076653033;
      4'd8:    r = 31'd1075196443;
      4'd9:    r = 31'd1074468888;
      4'd10:   r = 31'd1074105294;
      4'd11:   r = 31'd1073923544;
      4'd12:   r = 31'd1073832680;
      4'd13:   r = 31'd1073787251;
      4'd14:   r = 31'd1073764537;
      default: r = 31'd1073753181;
    endcase
    return r;
  endfunction

endpackage

[rtl/gas_sensor_ppm_converter.sv]
// Gas sensor ppm converter.
// Input stream: s_axis carries one ADC sample per item, tuser selects
// calibration (1) or measurement (0). Output stream: m_axis carries one
// result item per input item: concentration and resistance in tdata, the
// status flags in tuser. Registers are to be written over the cfg port only
// while idle; the block itself does not enforce this. One item is worked on
// at a time by a sequencer around one shared 32x32 multiplier and a
// bit-serial restoring divider. Steps per item: a zero sample or no positive
// resistance goes straight to the post step, else rs is found by a division;
// a completing calibration sample adds a multiply and a division for ro; a
// full measurement adds two log2 passes (normalize, squaring and an end step
// each), the exponent product, exp2 and scaling. A new item is accepted no
// earlier than the cycle after the previous one has moved to the output
// register; a stalled receiver holds that register and the next item then
// waits in the last sequencer step until the register frees.
// Reset restores the register defaults and clears the calibration; the
// block reports fault on measurement samples until a calibration completes
// with a nonzero ro.
`include "gas_sensor_ppm_converter_macros.svh"

module gas_sensor_ppm_converter #(
  parameter int CAL_SAMPLES = gspc_pkg::CAL_SAMPLES_DEF,
  parameter int ADC_BITS    = gspc_pkg::ADC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] concentration, [47:24] resistance
  output logic [3:0]  m_axis_tuser,   // [0] concentration_valid, [1] calibration_done,
                                      // [2] fault, [3] saturated
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int DDW    = 43;
  localparam int CAL_DV = CAL_SAMPLES * gspc_pkg::RO_DIV;
  localparam int DVB    = $clog2(CAL_DV + 1);
  localparam int DIVW   = (DVB > 14) ? DVB : 14;
  localparam int REMW   = DIVW + 1;
  localparam int CW     = $clog2(CAL_SAMPLES + 1);
  localparam logic [11:0] ADC_MASK = 12'((33'd1 << ADC_BITS) - 33'd1);

  localparam logic [1:0] REG_SUPPLY = 2'd0;
  localparam logic [1:0] REG_LOAD   = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_EXPO   = 2'd3;

  gspc_pkg::gspc_state_e state_q, state_d;

  // configuration and calibration state
  logic [15:0]        supply_q;
  logic [23:0]        load_q, scale_q;
  logic signed [15:0] expo_q;
  logic [31:0]        sum_q, sum_d;
  logic [CW-1:0]      ccnt_q, ccnt_d;
  logic [23:0]        ro_q, ro_d;
  logic               calib_q, calib_d;

  // per item datapath
  logic               mode_q, mode_d;
  logic [11:0]        smp_q, smp_d;
  logic signed [20:0] num_q, num_d;
  logic [23:0]        rs_q, rs_d, conc_q, conc_d;
  logic               sat_q, sat_d, fault_q, fault_d, valid_q, valid_d, done_q, done_d;
  logic [DDW-1:0]     dd_q, dd_d;
  logic [REMW-1:0]    rem_q, rem_d;
  logic [DIVW-1:0]    dv_q, dv_d;
  logic               dest_q, dest_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [30:0]        m_q, m_d;
  logic [4:0]         e_q, e_d;
  logic [15:0]        f_q, f_d;
  logic               lsel_q, lsel_d;
  logic [20:0]        lrs_q, lrs_d;
  logic signed [37:0] p_q, p_d;
  logic [54:0]        v_q, v_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [47:0] odata_q, odata_d;
  logic [3:0]  ouser_q, ouser_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  assign prod = 64'(mul_a) * 64'(mul_b);

  logic [REMW-1:0]    rem_sh;
  logic [32:0]        sum_add;
  logic [31:0]        sq_t;
  logic signed [21:0] ldiff;
  logic [20:0]        dmag;
  logic [15:0]        bmag;
  logic signed [10:0] sh;
  logic [54:0]        shr;
  logic [CW:0]        ccnt_inc;
  logic [11:0]        smp_in;
  logic [18:0]        five_v;

  assign s_axis_tready = (state_q == gspc_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  always_comb begin
    state_d = state_q;
    sum_d = sum_q; ccnt_d = ccnt_q; ro_d = ro_q; calib_d = calib_q;
    mode_d = mode_q; smp_d = smp_q; num_d = num_q;
    rs_d = rs_q; conc_d = conc_q;
    sat_d = sat_q; fault_d = fault_q; valid_d = valid_q; done_d = done_q;
    dd_d = dd_q; rem_d = rem_q; dv_d = dv_q; dest_d = dest_q; cnt_d = cnt_q;
    m_d = m_q; e_d = e_q; f_d = f_q; lsel_d = lsel_q; lrs_d = lrs_q;
    p_d = p_q; v_d = v_q;
    ovalid_d = ovalid_q; odata_d = odata_q; ouser_d = ouser_q;
    mul_a = 32'd0;
    mul_b = 32'd0;

    smp_in   = s_axis_tdata[11:0] & ADC_MASK;
    five_v   = {1'b0, supply_q, 2'b00} + 19'(supply_q);
    rem_sh   = {rem_q[REMW-2:0], dd_q[DDW-1]};
    sum_add  = 33'(sum_q) + 33'(rs_q);
    sq_t     = prod[61:30];
    ldiff    = $signed({1'b0, lrs_q}) - $signed({1'b0, e_q, f_q});
    dmag     = ldiff[21] ? 21'(-ldiff) : ldiff[20:0];
    bmag     = expo_q[15] ? 16'(-expo_q) : 16'(expo_q);
    sh       = 11'sd34 - 11'($signed(p_q[37:28]));
    shr      = v_q >> sh[5:0];
    ccnt_inc = (CW + 1)'(ccnt_q) + (CW + 1)'(1);

    // output register frees when the receiver takes the item
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      gspc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = s_axis_tuser;
          smp_d   = smp_in;
          num_d   = $signed({2'b00, five_v}) - $signed({7'd0, smp_in, 2'b00});
          sat_d   = 1'b0; fault_d = 1'b0; valid_d = 1'b0; done_d = 1'b0;
          conc_d  = 24'd0;
          state_d = gspc_pkg::ST_RES;
        end
      end
      // resistance: zero sample, no positive numerator, or divide L*num by 4*sample
      gspc_pkg::ST_RES: begin
        mul_a = 32'(load_q);
        mul_b = 32'(num_q[19:0]);
        if (smp_q == 12'd0) begin
          rs_d = 24'(gspc_pkg::MAX24); sat_d = 1'b1; fault_d = 1'b1;
          state_d = gspc_pkg::ST_POST;
        end else if (num_q <= 21'sd0) begin
          rs_d = 24'd0;
          state_d = gspc_pkg::ST_POST;
        end else begin
          dd_d = prod[DDW-1:0]; rem_d = '0; dv_d = DIVW'({smp_q, 2'b00});
          cnt_d = 6'd0; dest_d = 1'b0;
          state_d = gspc_pkg::ST_DIV;
        end
      end
      // restoring divider, one quotient bit per cycle
      gspc_pkg::ST_DIV: begin
        if (rem_sh >= REMW'(dv_q)) begin
          rem_d = rem_sh - REMW'(dv_q);
          dd_d  = {dd_q[DDW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          dd_d  = {dd_q[DDW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DDW - 1)) state_d = gspc_pkg::ST_DIVEND;
      end
      gspc_pkg::ST_DIVEND: begin
        if (!dest_q) begin
          if (|dd_q[DDW-1:24]) begin
            rs_d = 24'(gspc_pkg::MAX24); sat_d = 1'b1;
          end else begin
            rs_d = dd_q[23:0];
          end
          state_d = gspc_pkg::ST_POST;
        end else begin
          ro_d    = (|dd_q[DDW-1:24]) ? 24'(gspc_pkg::MAX24) : dd_q[23:0];
          calib_d = (dd_q != '0);
          sum_d   = 32'd0;
          ccnt_d  = '0;
          done_d  = 1'b1;
          state_d = gspc_pkg::ST_OUT;
        end
      end
      gspc_pkg::ST_POST: begin
        if (mode_q) begin
          // calibration accumulate, saturating
          sum_d = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
          if (ccnt_inc >= (CW + 1)'(CAL_SAMPLES)) begin
            state_d = gspc_pkg::ST_MULCAL;
          end else begin
            ccnt_d  = ccnt_inc[CW-1:0];
            state_d = gspc_pkg::ST_OUT;
          end
        end else if (fault_q) begin
          state_d = gspc_pkg::ST_OUT;
        end else if (!calib_q) begin
          fault_d = 1'b1;
          state_d = gspc_pkg::ST_OUT;
        end else if (scale_q == 24'd0) begin
          valid_d = 1'b1;
          state_d = gspc_pkg::ST_OUT;
        end else if (rs_q == 24'd0) begin
          valid_d = 1'b1;
          if (expo_q > 16'sd0) conc_d = 24'd0;
          else if (expo_q == 16'sd0) conc_d = {4'd0, scale_q[23:4]};
          else begin
            conc_d = 24'(gspc_pkg::MAX24); sat_d = 1'b1;
          end
          state_d = gspc_pkg::ST_OUT;
        end else begin
          m_d = {rs_q, 7'd0}; e_d = 5'd23; lsel_d = 1'b0;
          state_d = gspc_pkg::ST_NORM;
        end
      end
      gspc_pkg::ST_MULCAL: begin
        mul_a = sum_q;
        mul_b = 32'(gspc_pkg::RO_MUL);
        dd_d = prod[DDW-1:0]; rem_d = '0; dv_d = DIVW'(CAL_DV);
        cnt_d = 6'd0; dest_d = 1'b1;
        state_d = gspc_pkg::ST_DIV;
      end
      // log2: shift the mantissa up one bit a cycle
      gspc_pkg::ST_NORM: begin
        if (m_q[30]) begin
          cnt_d = 6'd0; f_d = 16'd0;
          state_d = gspc_pkg::ST_SQ;
        end else begin
          m_d = {m_q[29:0], 1'b0};
          e_d = e_q - 5'd1;
        end
      end
      // log2 fraction by repeated squaring, one bit a cycle
      gspc_pkg::ST_SQ: begin
        mul_a = 32'(m_q);
        mul_b = 32'(m_q);
        if (sq_t[31]) begin
          m_d = sq_t[31:1]; f_d = {f_q[14:0], 1'b1};
        end else begin
          m_d = sq_t[30:0]; f_d = {f_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd15) state_d = gspc_pkg::ST_LOGEND;
      end
      gspc_pkg::ST_LOGEND: begin
        if (!lsel_q) begin
          lrs_d = {e_q, f_q};
          m_d = {ro_q, 7'd0}; e_d = 5'd23; lsel_d = 1'b1;
          state_d = gspc_pkg::ST_NORM;
        end else begin
          state_d = gspc_pkg::ST_MULP;
        end
      end
      // exponent b * (log2 rs - log2 ro), sign by magnitude
      gspc_pkg::ST_MULP: begin
        mul_a = 32'(bmag);
        mul_b = 32'(dmag);
        p_d = (expo_q[15] ^ ldiff[21]) ? -$signed({1'b0, prod[36:0]})
                                       : $signed({1'b0, prod[36:0]});
        m_d = 31'd1 << 30;
        cnt_d = 6'd0;
        state_d = gspc_pkg::ST_EXP;
      end
      // exp2 of the fraction, one fraction bit a cycle
      gspc_pkg::ST_EXP: begin
        mul_a = 32'(m_q);
        mul_b = 32'(gspc_pkg::exp2_root(cnt_q[3:0]));
        if (p_q[12 + 15 - cnt_q[3:0]]) m_d = prod[60:30];
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd15) state_d = gspc_pkg::ST_MULA;
      end
      gspc_pkg::ST_MULA: begin
        mul_a = 32'(scale_q);
        mul_b = 32'(m_q);
        v_d = prod[54:0];
        state_d = gspc_pkg::ST_SHIFT;
      end
      // scale by 2^int and clip to Q20.4
      gspc_pkg::ST_SHIFT: begin
        valid_d = 1'b1;
        if (sh >= 11'sd55) begin
          conc_d = 24'd0;
        end else if (sh <= 11'sd0) begin
          conc_d = 24'(gspc_pkg::MAX24); sat_d = 1'b1;
        end else if (|shr[54:24]) begin
          conc_d = 24'(gspc_pkg::MAX24); sat_d = 1'b1;
        end else begin
          conc_d = shr[23:0];
        end
        state_d = gspc_pkg::ST_OUT;
      end
      gspc_pkg::ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {rs_q, conc_q};
          ouser_d  = {sat_q, fault_q, done_q, valid_q};
          state_d  = gspc_pkg::ST_IDLE;
        end
      end
      default: state_d = gspc_pkg::ST_IDLE;
    endcase
  end

  // control, configuration and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gspc_pkg::ST_IDLE;
      supply_q <= 16'd5000;
      load_q   <= 24'd10000;
      scale_q  <= 24'd256;
      expo_q   <= -16'sd4096;
      sum_q    <= 32'd0;
      ccnt_q   <= '0;
      ro_q     <= 24'd0;
      calib_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      ccnt_q   <= ccnt_d;
      ro_q     <= ro_d;
      calib_q  <= calib_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SUPPLY: supply_q <= cfg_data_i[15:0];
          REG_LOAD:   load_q   <= cfg_data_i;
          REG_SCALE:  scale_q  <= cfg_data_i;
          REG_EXPO:   expo_q   <= $signed(cfg_data_i[15:0]);
          default:    ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; smp_q <= smp_d; num_q <= num_d;
    rs_q <= rs_d; conc_q <= conc_d;
    sat_q <= sat_d; fault_q <= fault_d; valid_q <= valid_d; done_q <= done_d;
    dd_q <= dd_d; rem_q <= rem_d; dv_q <= dv_d; dest_q <= dest_d; cnt_q <= cnt_d;
    m_q <= m_d; e_q <= e_d; f_q <= f_d; lsel_q <= lsel_d; lrs_q <= lrs_d;
    p_q <= p_d; v_q <= v_d;
    odata_q <= odata_d; ouser_q <= ouser_d;
  end

  // a concentration is never given together with a fault
  `GSPC_ASSERT_ALWAYS(a_valid_no_fault, !(ovalid_q && ouser_q[0] && ouser_q[2]),
                      "concentration given with fault")
  // calibration completion and a concentration exclude each other
  `GSPC_ASSERT_ALWAYS(a_done_no_conc, !(ovalid_q && ouser_q[0] && ouser_q[1]),
                      "calibration done with concentration")
  // an accepted item keeps the input closed the next cycle
  `GSPC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready, "input open right after accept")

endmodule

[test/gas_sensor_ppm_converter_tb.sv]
`timescale 1ns / 1ps

module gas_sensor_ppm_converter_tb;

  localparam logic [1:0] REG_SUPPLY   = 2'd0;
  localparam logic [1:0] REG_LOAD     = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;
  localparam logic [1:0] REG_EXPONENT = 2'd3;
  localparam bit MODE_MEASURE = 1'b0;
  localparam bit MODE_CAL     = 1'b1;
  localparam int CAL_LEN      = 25;
  localparam logic [23:0] SAT24 = 24'hFFFFFF;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [23:0] conc;
    logic        conc_valid;
    logic [23:0] rs;
    logic        cal_done;
    logic        fault;
    logic        sat;
  } reading_t;

  typedef struct {
    bit          mode;
    logic [11:0] sample;
    bit          typed;
    reading_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] sample
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [23:0] concentration, [47:24] resistance
  logic [3:0]  m_axis_tuser;        // [0] conc valid, [1] cal done, [2] fault, [3] sat
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  gas_sensor_ppm_converter u_top (.*);

  // 2^(2^-(k+1)) in Q30
  localparam logic [30:0] ROOT_Q30 [16] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181};

  // shadow registers and sensor state
  logic [15:0] supply_mv;
  logic [23:0] load_r;
  logic [23:0] scale_a;
  logic signed [15:0] expo_b;
  logic [31:0] rs_sum;
  int unsigned cal_cnt;
  logic [23:0] ro_clean;
  bit          is_calibrated;

  reading_t    readings_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  bit          rcv_hold = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // log2 in Q.16, bit-serial squaring
  function automatic longint log2_q16(input logic [31:0] x);
    int e;
    logic [63:0] m;
    logic [15:0] f;
    e = 0;
    f = '0;
    while (e < 23 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    return (longint'(e) <<< 16) + longint'(f);
  endfunction

  function automatic logic [23:0] power_law(input logic [23:0] rs, ref bit sat);
    longint p, e, ip, sh;
    logic [15:0] f;
    logic [63:0] m, v, r;
    if (scale_a == 0) return '0;
    if (rs == 0) begin
      if (expo_b > 0) return '0;
      if (expo_b == 0) return scale_a >> 4;
      sat = 1'b1;
      return SAT24;
    end
    p = longint'(expo_b) * (log2_q16(rs) - log2_q16(ro_clean));
    e = p >>> 12;
    ip = e >>> 16;
    f = e[15:0];
    m = 64'd1 << 30;
    for (int j = 0; j < 16; j++)
      if (f[15-j]) m = (m * ROOT_Q30[j]) >> 30;
    v = 64'(scale_a) * m;
    sh = 34 - ip;
    if (sh >= 64) return '0;
    if (sh <= 0) begin
      sat = 1'b1;
      return SAT24;
    end
    r = v >> sh;
    if (r > SAT24) begin
      sat = 1'b1;
      return SAT24;
    end
    return r[23:0];
  endfunction

  // next reading for one sample, updates the calibration state
  function automatic reading_t convert_sample(input bit mode, input logic [11:0] smp);
    reading_t o;
    bit sat;
    longint num;
    logic [63:0] q, sum, ro;
    o = '0;
    sat = 1'b0;
    if (smp == 0) begin
      o.rs = SAT24;
      sat = 1'b1;
      o.fault = 1'b1;
    end else begin
      num = 5 * longint'(supply_mv) - 4 * longint'(smp);
      if (num <= 0) o.rs = '0;
      else begin
        q = (64'(load_r) * 64'(num)) / (64'd4 * smp);
        if (q > SAT24) begin
          sat = 1'b1;
          o.rs = SAT24;
        end else o.rs = q[23:0];
      end
    end
    if (mode == MODE_CAL) begin
      sum = 64'(rs_sum) + o.rs;
      rs_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      cal_cnt++;
      if (cal_cnt >= CAL_LEN) begin
        ro = (64'(rs_sum) * 100) / (CAL_LEN * 983);
        if (ro > SAT24) ro = SAT24;
        ro_clean = ro[23:0];
        is_calibrated = (ro != 0);
        rs_sum = '0;
        cal_cnt = 0;
        o.cal_done = 1'b1;
      end
    end else if (!o.fault) begin
      if (!is_calibrated) o.fault = 1'b1;
      else begin
        o.conc = power_law(o.rs, sat);
        o.conc_valid = 1'b1;
      end
    end
    o.sat = sat;
    return o;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SUPPLY:   supply_mv = val[15:0];
      REG_LOAD:     load_r = val;
      REG_SCALE:    scale_a = val;
      REG_EXPONENT: expo_b = val[15:0];
      default: ;
    endcase
  endtask

  // offer one item, valid held until accepted
  task automatic send_sample(input bit mode, input logic [11:0] smp, input bit typed,
                             input reading_t want);
    reading_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, smp};
    s_axis_tuser <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = convert_sample(mode, smp);
    readings_q.push_back(typed ? want : pred);
  endtask

  // drain and let the sequencer settle before touching registers
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (readings_q.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'd1;
      2: return 12'hFFF;
      3: return 12'($urandom_range(1, 64));
      default: return 12'($urandom);
    endcase
  endfunction

  // receiver ready
  always @(negedge clk_i) begin
    m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
  end

  // long receiver hold-off
  initial begin
    wait (hold_req);
    @(negedge clk_i);
    rcv_hold = 1'b1;
    repeat (600) @(negedge clk_i);
    rcv_hold = 1'b0;
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    reading_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[23:0], m_axis_tuser[0], m_axis_tdata[47:24],
             m_axis_tuser[1], m_axis_tuser[2], m_axis_tuser[3]};
      if (readings_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = readings_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: conc %h/%h cv %b/%b rs %h/%h done %b/%b fault %b/%b sat %b/%b",
                     want.conc, got.conc, want.conc_valid, got.conc_valid, want.rs, got.rs,
                     want.cal_done, got.cal_done, want.fault, got.fault, want.sat, got.sat);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    reading_t zero_fault;
    int sent;
    int n_meas;

    supply_mv = 16'd5000;
    load_r = 24'd10000;
    scale_a = 24'd256;
    expo_b = -16'sd4096;
    rs_sum = '0;
    cal_cnt = 0;
    ro_clean = '0;
    is_calibrated = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table: uncalibrated measures, a full calibration, then measures
    zero_fault = '{conc: '0, conc_valid: 1'b0, rs: SAT24, cal_done: 1'b0,
                   fault: 1'b1, sat: 1'b1};
    rows.push_back('{MODE_MEASURE, 12'd0, 1'b1, zero_fault});
    rows.push_back('{MODE_MEASURE, 12'hFFF, 1'b0, '0});
    rows.push_back('{MODE_MEASURE, 12'd1, 1'b0, '0});
    for (int i = 0; i < CAL_LEN; i++)
      rows.push_back('{MODE_CAL, (i == 0) ? 12'd0 : (i == 1) ? 12'hFFF :
                       12'(1200 + 37 * i), 1'b0, '0});
    rows.push_back('{MODE_MEASURE, 12'd0, 1'b1, zero_fault});
    rows.push_back('{MODE_MEASURE, 12'd1, 1'b0, '0});
    rows.push_back('{MODE_MEASURE, 12'hFFF, 1'b0, '0});
    rows.push_back('{MODE_MEASURE, 12'd1500, 1'b0, '0});
    foreach (rows[i]) begin
      rw = rows[i];
      send_sample(rw.mode, rw.sample, rw.typed, rw.want);
    end
    wait_idle();

    // random phases under changing register settings
    sent = 0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_SUPPLY, 24'd5000);
          cfg_write(REG_LOAD, 24'd10000);
          cfg_write(REG_SCALE, 24'd256);
          cfg_write(REG_EXPONENT, 24'h00F000);
        end
        1: begin
          cfg_write(REG_SUPPLY, 24'd65535);
          cfg_write(REG_LOAD, SAT24);
          cfg_write(REG_SCALE, SAT24);
          cfg_write(REG_EXPONENT, 24'h007FFF);
        end
        2: begin
          cfg_write(REG_SUPPLY, 24'd1);
          cfg_write(REG_LOAD, 24'd1);
          cfg_write(REG_SCALE, 24'd0);
          cfg_write(REG_EXPONENT, 24'h008000);
        end
        3: begin
          cfg_write(REG_SUPPLY, 24'd3300);
          cfg_write(REG_LOAD, 24'd4700);
          cfg_write(REG_SCALE, 24'($urandom));
          cfg_write(REG_EXPONENT, 24'd0);
        end
        default: begin
          cfg_write(REG_SUPPLY, 24'($urandom_range(2000, 6000)));
          cfg_write(REG_LOAD, 24'($urandom_range(1000, 100000)));
          cfg_write(REG_SCALE, 24'($urandom));
          cfg_write(REG_EXPONENT, 24'($urandom_range(0, 65535)));
        end
      endcase

      snd_idle = (ph < 3) ? 24 : (ph < 6) ? 83 : 0;
      rcv_idle = (ph < 3) ? 83 : (ph < 6) ? 24 : 0;
      if (ph == 4) hold_req = 1'b1;

      for (int k = 0; k < 180;) begin
        if ($urandom_range(9) < 7) begin
          // calibration run followed by a burst of measures
          for (int c = 0; c < CAL_LEN; c++) send_sample(MODE_CAL, pick_sample(), 1'b0, '0);
          n_meas = $urandom_range(5, 20);
          for (int c = 0; c < n_meas; c++)
            send_sample(MODE_MEASURE, pick_sample(), 1'b0, '0);
          k += CAL_LEN + n_meas;
        end else begin
          send_sample(1'($urandom), pick_sample(), 1'b0, '0);
          k++;
        end
        if (ph == 7 && k > 100 && k < 140) begin
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          wait (readings_q.size() == 0);
        end
      end
      wait_idle();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/gspc_pkg.sv
rtl/gas_sensor_ppm_converter.sv
test/gas_sensor_ppm_converter_tb.sv
